// ===== hw/rtl/dcpc_pkg.sv =====
`default_nettype none

package dcpc_pkg;

    // Register and counter widths
    localparam int CFG_W      = 12;
    localparam int COUNT_BITS = 12;
    localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int N_TIMERS   = 6;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Timer slots, also the configuration register indexes
    localparam int T_AVI   = 0;
    localparam int T_PVARP = 1;
    localparam int T_VRP   = 2;
    localparam int T_AEI   = 3;
    localparam int T_LRI   = 4;
    localparam int T_URI   = 5;

    // Interval lengths after reset, in ms
    localparam logic [CFG_W-1:0] LEN_RESET [N_TIMERS] = '{
        12'd300, 12'd50, 12'd150, 12'd800, 12'd950, 12'd900
    };

    typedef enum logic [2:0] {
        S_IDLE       = 3'd0,
        S_APULSE     = 3'd1,
        S_AVISTART   = 3'd2,
        S_STARTOTHER = 3'd3,
        S_STOPV      = 3'd4,
        S_STOPA      = 3'd5,
        S_VPULSE     = 3'd6,
        S_EXTEND     = 3'd7
    } dcpc_state_t;

    // Timer status after the tick phase of a step
    typedef struct packed {
        logic [N_TIMERS-1:0] expired;
        logic                a_win;
        logic                v_win;
    } dcpc_tstat_t;

    // Timer commands issued by the controller
    typedef struct packed {
        logic [N_TIMERS-1:0] start;
        logic [N_TIMERS-1:0] stop;
    } dcpc_tcmd_t;

    // One result item
    typedef struct packed {
        logic        atrial_pace;
        logic        ventricular_pace;
        dcpc_state_t fsm_state;
        logic        atrial_window_open;
        logic        ventricular_window_open;
    } dcpc_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dcpc_if.sv =====
`default_nettype none

// Input item channel
interface dcpc_in_if import dcpc_pkg::*; ();
    logic valid;
    logic ready;
    logic atrial_sense;
    logic ventricular_sense;
    logic ms_tick;

    modport source (output valid, atrial_sense, ventricular_sense, ms_tick, input ready);
    modport sink   (input valid, atrial_sense, ventricular_sense, ms_tick, output ready);
endinterface

// Result item channel
interface dcpc_out_if import dcpc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       atrial_pace;
    logic       ventricular_pace;
    logic [2:0] fsm_state;
    logic       atrial_window_open;
    logic       ventricular_window_open;

    modport source (output valid, atrial_pace, ventricular_pace, fsm_state,
                    atrial_window_open, ventricular_window_open, input ready);
    modport sink   (input valid, atrial_pace, ventricular_pace, fsm_state,
                    atrial_window_open, ventricular_window_open, output ready);
endinterface

// Configuration write channel
interface dcpc_cfg_if import dcpc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dual_chamber_pacing_controller.sv =====
// Dual-chamber pacing timing controller.
// item:   one transaction per controller step, carrying atrial_sense,
//         ventricular_sense and ms_tick (one millisecond elapsed).
// result: one transaction per item, carrying the pace flags, the controller
//         state and both sensing windows as they stand after the step.
// cfg:    writes the six interval lengths in ms (index 0 AVI, 1 PVARP,
//         2 VRP, 3 AEI, 4 LRI, 5 URI); always ready, indexes 6 and 7 are
//         dropped. Write only while no result is outstanding.
// Timing: the timer tick and one controller transition are evaluated in
//         the cycle an item is accepted; the result is registered in the
//         output stage. One item per cycle is sustained if results are taken.
// Stall:  a two-entry output stage (output register plus skid) keeps item
//         ready high while one result waits; item ready drops only when both
//         entries are full, and no result is lost or repeated.
// Reset:  rst_n clears the controller to idle with first-beat set, both
//         windows open, all timers stopped (URI marked expired) and the
//         interval lengths at 300/50/150/800/950/900 ms.
`default_nettype none

module dual_chamber_pacing_controller import dcpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcpc_in_if.sink    item,
    dcpc_out_if.source result,
    dcpc_cfg_if.sink   cfg
);

    logic         accept;
    logic         push_ready;
    dcpc_tstat_t  stat;
    dcpc_tcmd_t   cmd;
    dcpc_state_t  state_next;
    logic         ap_next, vp_next;
    logic         a_win_final, v_win_final;
    dcpc_result_t res;

    assign item.ready = push_ready;
    assign accept     = item.valid && push_ready;

    dcpc_timers u_timers (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .tick        (item.ms_tick),
        .cmd         (cmd),
        .stat        (stat),
        .a_win_final (a_win_final),
        .v_win_final (v_win_final)
    );

    dcpc_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .atrial_sense      (item.atrial_sense),
        .ventricular_sense (item.ventricular_sense),
        .stat              (stat),
        .cmd               (cmd),
        .state_next        (state_next),
        .ap_next           (ap_next),
        .vp_next           (vp_next)
    );

    // Result of this step
    assign res.atrial_pace             = ap_next;
    assign res.ventricular_pace        = vp_next;
    assign res.fsm_state               = state_next;
    assign res.atrial_window_open      = a_win_final;
    assign res.ventricular_window_open = v_win_final;

    dcpc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (res),
        .push_ready (push_ready),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dcpc_timers.sv =====
`default_nettype none

module dcpc_timers import dcpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    dcpc_cfg_if.sink         cfg,
    input  wire logic        accept,
    input  wire logic        tick,
    input  wire dcpc_tcmd_t  cmd,
    output dcpc_tstat_t      stat,
    output logic             a_win_final,
    output logic             v_win_final
);

    logic [CFG_W-1:0]      len_reg [N_TIMERS];
    logic [COUNT_BITS-1:0] cnt_reg [N_TIMERS];
    logic [COUNT_BITS-1:0] cnt_next [N_TIMERS];
    logic [COUNT_BITS-1:0] cnt_tick [N_TIMERS];
    logic [N_TIMERS-1:0]   running_reg, running_next, running_tick;
    logic [N_TIMERS-1:0]   expired_reg, expired_next, expired_tick;
    logic [N_TIMERS-1:0]   fire;
    logic                  a_win_reg, v_win_reg;

    assign cfg.ready = 1'b1;

    // Interval length registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_TIMERS; i++)
                len_reg[i] <= LEN_RESET[i];
        end
        else if (cfg.valid && (int'(cfg.index) < N_TIMERS))
        begin
            len_reg[cfg.index] <= cfg.data;
        end
    end

    // Tick phase, then start and stop commands, each timer on its own
    always_comb
    begin
        logic [COUNT_BITS-1:0] inc;
        logic [CMP_W-1:0]      len_eff;
        for (int t = 0; t < N_TIMERS; t++)
        begin
            inc      = (cnt_reg[t] == COUNT_MAX) ? cnt_reg[t] : cnt_reg[t] + 1'b1;
            len_eff  = (CMP_W'(len_reg[t]) > CMP_W'(COUNT_MAX)) ?
                       CMP_W'(COUNT_MAX) : CMP_W'(len_reg[t]);
            fire[t]  = tick && running_reg[t] && (CMP_W'(inc) >= len_eff);

            cnt_tick[t]     = cnt_reg[t];
            running_tick[t] = running_reg[t];
            expired_tick[t] = expired_reg[t];
            if (fire[t])
            begin
                cnt_tick[t]     = '0;
                running_tick[t] = 1'b0;
                expired_tick[t] = 1'b1;
            end
            else if (tick && running_reg[t])
            begin
                cnt_tick[t] = inc;
            end

            cnt_next[t]     = cnt_tick[t];
            running_next[t] = running_tick[t];
            expired_next[t] = expired_tick[t];
            if (cmd.start[t] && !running_tick[t])
            begin
                cnt_next[t]     = '0;
                running_next[t] = 1'b1;
                expired_next[t] = 1'b0;
            end
            else if (cmd.stop[t] && running_tick[t])
            begin
                running_next[t] = 1'b0;
                expired_next[t] = 1'b1;
            end
        end
    end

    // Refractory expiry reopens a window, a refractory start closes it
    assign stat.expired = expired_tick;
    assign stat.a_win   = a_win_reg | fire[T_PVARP];
    assign stat.v_win   = v_win_reg | fire[T_VRP];
    assign a_win_final  = stat.a_win & ~(cmd.start[T_PVARP] & ~running_tick[T_PVARP]);
    assign v_win_final  = stat.v_win & ~(cmd.start[T_VRP] & ~running_tick[T_VRP]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_TIMERS; i++)
                cnt_reg[i] <= '0;
            running_reg <= '0;
            expired_reg <= N_TIMERS'(1) << T_URI;
            a_win_reg   <= 1'b1;
            v_win_reg   <= 1'b1;
        end
        else if (accept)
        begin
            for (int i = 0; i < N_TIMERS; i++)
                cnt_reg[i] <= cnt_next[i];
            running_reg <= running_next;
            expired_reg <= expired_next;
            a_win_reg   <= a_win_final;
            v_win_reg   <= v_win_final;
        end
    end

    // A timer is never running and expired at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg & expired_reg) == '0)
        else $error("timer both running and expired");

endmodule

`default_nettype wire

// ===== hw/rtl/dcpc_ctrl.sv =====
`default_nettype none

module dcpc_ctrl import dcpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        atrial_sense,
    input  wire logic        ventricular_sense,
    input  wire dcpc_tstat_t stat,
    output dcpc_tcmd_t       cmd,
    output dcpc_state_t      state_next,
    output logic             ap_next,
    output logic             vp_next
);

    dcpc_state_t state_reg;
    logic        first_beat_reg, first_beat_next;
    logic        asl_reg, asl_next;
    logic        vsl_reg, vsl_next;
    logic        ap_reg, vp_reg;

    logic as_i, vs_i, aw, vw, avi_exp, uri_exp, lri_exp, aei_exp;
    logic a_go, v_go;

    assign as_i    = atrial_sense;
    assign vs_i    = ventricular_sense;
    assign aw      = stat.a_win;
    assign vw      = stat.v_win;
    assign avi_exp = stat.expired[T_AVI];
    assign uri_exp = stat.expired[T_URI];
    assign lri_exp = stat.expired[T_LRI];
    assign aei_exp = stat.expired[T_AEI];

    // Idle: atrial event wins over a pending ventricular one
    assign a_go = aw && ((as_i && first_beat_reg) || ap_reg || asl_reg);
    assign v_go = vw && !first_beat_reg && (vp_reg || vsl_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (a_go)
                    state_next = S_AVISTART;
                else if (v_go)
                    state_next = S_STARTOTHER;
            end
            S_APULSE:
            begin
                if (vw)
                begin
                    priority if (first_beat_reg)
                    begin
                        if (avi_exp != vs_i)
                            state_next = S_STOPV;
                    end
                    else if (!uri_exp)
                    begin
                        if (avi_exp)
                            state_next = S_EXTEND;
                    end
                    else if (lri_exp || (avi_exp != vs_i))
                    begin
                        state_next = S_STOPV;
                    end
                    else
                    begin
                        // still waiting on the AV interval or a sensed beat
                    end
                end
            end
            S_EXTEND:
            begin
                if (vw && uri_exp)
                    state_next = S_STOPV;
            end
            S_AVISTART:   state_next = S_APULSE;
            S_STARTOTHER: state_next = S_VPULSE;
            S_STOPV:      state_next = S_IDLE;
            S_STOPA:      state_next = S_IDLE;
            S_VPULSE:
            begin
                if (aw && (aei_exp ? !as_i : as_i))
                    state_next = S_STOPA;
            end
        endcase
    end

    // Flags, latches and timer commands
    always_comb
    begin
        first_beat_next = first_beat_reg;
        asl_next        = asl_reg;
        vsl_next        = vsl_reg;
        ap_next         = ap_reg;
        vp_next         = vp_reg;
        cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (a_go)
                begin
                    if (!(as_i && first_beat_reg))
                    begin
                        ap_next  = 1'b0;
                        asl_next = 1'b0;
                    end
                end
                else if (v_go)
                begin
                    vp_next  = 1'b0;
                    vsl_next = 1'b0;
                end
            end
            S_APULSE:
            begin
                if (vw)
                begin
                    priority if (first_beat_reg)
                    begin
                        if (avi_exp && !vs_i)
                        begin
                            first_beat_next = 1'b0;
                            vp_next         = 1'b1;
                        end
                        else if (!avi_exp && vs_i)
                        begin
                            first_beat_next = 1'b0;
                            vsl_next        = 1'b1;
                        end
                    end
                    else if (!uri_exp)
                    begin
                        // AV extension, nothing latched here
                    end
                    else if (lri_exp || (avi_exp && !vs_i))
                    begin
                        vp_next = 1'b1;
                    end
                    else if (!avi_exp && vs_i)
                    begin
                        vsl_next = 1'b1;
                    end
                    else
                    begin
                        // nothing to latch yet
                    end
                end
            end
            S_EXTEND:
            begin
                if (vw && uri_exp)
                begin
                    if (vs_i)
                        vsl_next = 1'b1;
                    else
                        vp_next = 1'b1;
                end
            end
            S_AVISTART:
            begin
                cmd.start[T_AVI] = 1'b1;
            end
            S_STARTOTHER:
            begin
                cmd.start[T_AEI]   = 1'b1;
                cmd.start[T_URI]   = 1'b1;
                cmd.start[T_LRI]   = 1'b1;
                cmd.start[T_VRP]   = 1'b1;
                cmd.start[T_PVARP] = 1'b1;
            end
            S_STOPV:
            begin
                cmd.stop[T_AVI] = 1'b1;
                cmd.stop[T_AEI] = 1'b1;
                cmd.stop[T_URI] = 1'b1;
                cmd.stop[T_LRI] = 1'b1;
            end
            S_STOPA:
            begin
                cmd.stop[T_AEI] = 1'b1;
            end
            S_VPULSE:
            begin
                if (aw)
                begin
                    if (aei_exp && !as_i)
                        ap_next = 1'b1;
                    else if (!aei_exp && as_i)
                        asl_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_beat_reg <= 1'b1;
            asl_reg        <= 1'b0;
            vsl_reg        <= 1'b0;
            ap_reg         <= 1'b0;
            vp_reg         <= 1'b0;
        end
        else if (accept)
        begin
            state_reg      <= state_next;
            first_beat_reg <= first_beat_next;
            asl_reg        <= asl_next;
            vsl_reg        <= vsl_next;
            ap_reg         <= ap_next;
            vp_reg         <= vp_next;
        end
    end

    // Timer start state always hands over to the atrial pulse state
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg == S_AVISTART) |=> (state_reg == S_APULSE))
        else $error("AVI start did not advance");

    // First beat is only ever cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(first_beat_reg))
        else $error("first beat flag set again");

endmodule

`default_nettype wire

// ===== hw/rtl/dcpc_outq.sv =====
`default_nettype none

module dcpc_outq import dcpc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire dcpc_result_t push_data,
    output logic              push_ready,
    dcpc_out_if.source        result
);

    logic         out_valid_reg, skid_valid_reg;
    dcpc_result_t out_data_reg, skid_data_reg;
    logic         pop;

    assign pop        = out_valid_reg && result.ready;
    assign push_ready = !skid_valid_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

    assign result.valid                   = out_valid_reg;
    assign result.atrial_pace             = out_data_reg.atrial_pace;
    assign result.ventricular_pace        = out_data_reg.ventricular_pace;
    assign result.fsm_state               = out_data_reg.fsm_state;
    assign result.atrial_window_open      = out_data_reg.atrial_window_open;
    assign result.ventricular_window_open = out_data_reg.ventricular_window_open;

    // The skid stage only fills behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data with empty output stage");

endmodule

`default_nettype wire
